@@ sv/pbec_pkg.sv @@
package pbec_pkg;

    // Command codes as they arrive on the input channel.
    localparam logic [3:0] CMD_NOTIFY  = 4'd0;
    localparam logic [3:0] CMD_TICK    = 4'd1;
    localparam logic [3:0] CMD_OPEN    = 4'd2;
    localparam logic [3:0] CMD_CLOSE   = 4'd3;
    localparam logic [3:0] CMD_CLAIM   = 4'd4;
    localparam logic [3:0] CMD_RELEASE = 4'd5;
    localparam logic [3:0] CMD_READ    = 4'd6;
    localparam logic [3:0] CMD_CREATE  = 4'd7;
    localparam logic [3:0] CMD_POLL    = 4'd8;

    // Notify codes.
    localparam logic [7:0] NOTIFY_PRESS = 8'h80;
    localparam logic [7:0] NOTIFY_WAKE  = 8'h02;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BUSY    = 3'd1;
    localparam logic [2:0] ST_NODEV   = 3'd2;
    localparam logic [2:0] ST_INVALID = 3'd3;
    localparam logic [2:0] ST_PERM    = 3'd4;
    localparam logic [2:0] ST_UNKNOWN = 3'd5;

    // Result action codes.
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_WAKE     = 2'd1;
    localparam logic [1:0] ACT_SHUTDOWN = 2'd2;
    localparam logic [1:0] ACT_DEBUG    = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_BUTTON_ENABLE = 3'd0;
    localparam logic [2:0] CFG_ABORT_ENABLE  = 3'd1;
    localparam logic [2:0] CFG_DEBUGGER      = 3'd2;
    localparam logic [2:0] CFG_PRESS_COUNT   = 3'd3;
    localparam logic [2:0] CFG_WINDOW_TICKS  = 3'd4;

    // Saturation limit of the tick counters.
    localparam logic [16:0] TICK_MAX = 17'h1FFFF;

    // Session slot table, searched as groups of slots.
    localparam int SESSION_SLOTS = 256;
    localparam int GROUP_SIZE    = 16;
    localparam int GROUP_COUNT   = SESSION_SLOTS / GROUP_SIZE;

    typedef struct packed {
        logic        button_enable;
        logic        abort_enable;
        logic        debugger_present;
        logic [3:0]  abort_press_count;
        logic [15:0] abort_window_ticks;
    } cfg_t;

    // Operation after classification by the front end.
    typedef enum logic [3:0] {
        OP_OK      = 4'd0,
        OP_UNKNOWN = 4'd1,
        OP_PERM    = 4'd2,
        OP_INVALID = 4'd3,
        OP_PRESS   = 4'd4,
        OP_TICK    = 4'd5,
        OP_OPEN    = 4'd6,
        OP_CLOSE   = 4'd7,
        OP_CLAIM   = 4'd8,
        OP_RELEASE = 4'd9,
        OP_READ    = 4'd10,
        OP_CREATE  = 4'd11,
        OP_POLL    = 4'd12
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] session;
    } work_t;

    typedef struct packed {
        logic [2:0] status;
        logic [1:0] action;
        logic       event_pending;
        logic [7:0] new_session;
    } result_t;

endpackage

@@ sv/pbec_front.sv @@
module pbec_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [3:0]          s_command,
    input  logic [7:0]          s_notify_code,
    input  logic [7:0]          s_session,
    input  logic                s_privileged,
    input  pbec_pkg::cfg_t      cfg,
    output logic                push,
    output pbec_pkg::work_t     push_word,
    input  logic                queue_ready
);

    pbec_pkg::op_t op;

    // Decode the command into one operation, folding in the checks that
    // depend only on the word itself and the button enable.
    always_comb begin
        case (s_command)
            pbec_pkg::CMD_NOTIFY: begin
                if (s_notify_code == pbec_pkg::NOTIFY_WAKE) begin
                    op = pbec_pkg::OP_OK;
                end else if (s_notify_code != pbec_pkg::NOTIFY_PRESS) begin
                    op = pbec_pkg::OP_UNKNOWN;
                end else if (cfg.button_enable) begin
                    op = pbec_pkg::OP_PRESS;
                end else begin
                    op = pbec_pkg::OP_OK;
                end
            end
            pbec_pkg::CMD_TICK:    op = pbec_pkg::OP_TICK;
            pbec_pkg::CMD_OPEN:    op = pbec_pkg::OP_OPEN;
            pbec_pkg::CMD_CLOSE:   op = pbec_pkg::OP_CLOSE;
            pbec_pkg::CMD_CLAIM:   op = pbec_pkg::OP_CLAIM;
            pbec_pkg::CMD_RELEASE: op = pbec_pkg::OP_RELEASE;
            pbec_pkg::CMD_READ:    op = pbec_pkg::OP_READ;
            pbec_pkg::CMD_CREATE: begin
                op = s_privileged ? pbec_pkg::OP_CREATE : pbec_pkg::OP_PERM;
            end
            pbec_pkg::CMD_POLL:    op = pbec_pkg::OP_POLL;
            default:               op = pbec_pkg::OP_INVALID;
        endcase
    end

    assign s_ready           = queue_ready;
    assign push              = s_valid && queue_ready;
    assign push_word.op      = op;
    assign push_word.session = s_session;

endmodule

@@ sv/pbec_queue.sv @@
module pbec_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  pbec_pkg::work_t  push_word,
    output logic             push_ready,
    input  logic             pop,
    output pbec_pkg::work_t  pop_word,
    output logic             pop_valid
);

    pbec_pkg::work_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_word   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

@@ sv/pbec_back.sv @@
module pbec_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  pbec_pkg::cfg_t   cfg,
    input  logic             pop_valid,
    input  pbec_pkg::work_t  pop_word,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output pbec_pkg::result_t result
);

    localparam int SLOT_BITS  = $clog2(pbec_pkg::SESSION_SLOTS);
    localparam int GROUP_BITS = $clog2(pbec_pkg::GROUP_COUNT);
    localparam int MEMB_BITS  = $clog2(pbec_pkg::GROUP_SIZE);

    // Press sequence and event state.
    logic [3:0]  press_counter_reg, press_counter_next;
    logic        press_seen_reg, press_seen_next;
    logic [16:0] tslp_reg, tslp_next;
    logic        armed_reg, armed_next;
    logic [16:0] tsfp_reg, tsfp_next;
    logic        pending_reg, pending_next;
    logic [7:0]  owner_reg, owner_next;
    logic        latched_reg, latched_next;

    // Session slots and a per-group full flag for the free search.
    logic [pbec_pkg::SESSION_SLOTS-1:0] in_use_reg, in_use_next;
    logic [pbec_pkg::GROUP_COUNT-1:0]   group_full_reg, group_full_next;

    logic                 out_valid_reg;
    pbec_pkg::result_t    result_reg, result_next;

    logic                           any_free;
    logic [GROUP_BITS-1:0]          free_group;
    logic [pbec_pkg::GROUP_SIZE-1:0] group_bits;
    logic [MEMB_BITS-1:0]           free_member;
    logic [SLOT_BITS-1:0]           free_slot;

    logic [3:0]  cnt_new;
    logic [16:0] tsfp_inc;

    assign pop     = pop_valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign result  = result_reg;

    // Lowest group that still has a clear slot.
    always_comb begin
        any_free   = ~&group_full_reg;
        free_group = '0;
        for (int g = pbec_pkg::GROUP_COUNT - 1; g >= 0; g--) begin
            if (!group_full_reg[g]) begin
                free_group = GROUP_BITS'(g);
            end
        end
    end

    // Lowest clear slot inside that group; slot 0 is never handed out.
    always_comb begin
        group_bits = in_use_reg[free_group * pbec_pkg::GROUP_SIZE +: pbec_pkg::GROUP_SIZE];
        if (free_group == '0) begin
            group_bits[0] = 1'b1;
        end
        free_member = '0;
        for (int b = pbec_pkg::GROUP_SIZE - 1; b >= 0; b--) begin
            if (!group_bits[b]) begin
                free_member = MEMB_BITS'(b);
            end
        end
        free_slot = {free_group, free_member};
    end

    // Execute one operation.
    always_comb begin
        press_counter_next = press_counter_reg;
        press_seen_next    = press_seen_reg;
        tslp_next          = tslp_reg;
        armed_next         = armed_reg;
        tsfp_next          = tsfp_reg;
        pending_next       = pending_reg;
        owner_next         = owner_reg;
        latched_next       = latched_reg;
        in_use_next        = in_use_reg;
        result_next        = '{status: pbec_pkg::ST_OK, action: pbec_pkg::ACT_NONE,
                               event_pending: 1'b0, new_session: 8'd0};
        cnt_new            = 4'd0;
        tsfp_inc           = 17'd0;

        if (pop) begin
            case (pop_word.op)
                pbec_pkg::OP_OK: ;
                pbec_pkg::OP_UNKNOWN: result_next.status = pbec_pkg::ST_UNKNOWN;
                pbec_pkg::OP_PERM:    result_next.status = pbec_pkg::ST_PERM;
                pbec_pkg::OP_PRESS: begin
                    if (!(cfg.abort_enable && cfg.debugger_present)) begin
                        pending_next = 1'b1;
                        if (owner_reg != 8'd0) begin
                            result_next.action = pbec_pkg::ACT_WAKE;
                        end else if (!latched_reg) begin
                            latched_next       = 1'b1;
                            result_next.action = pbec_pkg::ACT_SHUTDOWN;
                        end
                    end else begin
                        if (!press_seen_reg || tslp_reg > {1'b0, cfg.abort_window_ticks}) begin
                            cnt_new = 4'd1;
                        end else begin
                            cnt_new = press_counter_reg + 4'd1;
                        end
                        press_counter_next = cnt_new;
                        press_seen_next    = 1'b1;
                        tslp_next          = 17'd0;
                        if (cnt_new >= cfg.abort_press_count) begin
                            press_counter_next = 4'd0;
                            press_seen_next    = 1'b0;
                            armed_next         = 1'b0;
                            tsfp_next          = 17'd0;
                            result_next.action = pbec_pkg::ACT_DEBUG;
                        end else if (cnt_new == 4'd1) begin
                            armed_next = 1'b1;
                            tsfp_next  = 17'd0;
                        end
                    end
                end
                pbec_pkg::OP_TICK: begin
                    if (press_seen_reg && tslp_reg < pbec_pkg::TICK_MAX) begin
                        tslp_next = tslp_reg + 17'd1;
                    end
                    if (armed_reg) begin
                        tsfp_inc = (tsfp_reg < pbec_pkg::TICK_MAX) ? tsfp_reg + 17'd1
                                                                    : tsfp_reg;
                        tsfp_next = tsfp_inc;
                        // Window expired: drop the sequence, set the event pending and request wake or shutdown.
                        if (tsfp_inc >= {1'b0, cfg.abort_window_ticks}) begin
                            press_counter_next = 4'd0;
                            press_seen_next    = 1'b0;
                            tslp_next          = 17'd0;
                            armed_next         = 1'b0;
                            tsfp_next          = 17'd0;
                            pending_next       = 1'b1;
                            if (owner_reg != 8'd0) begin
                                result_next.action = pbec_pkg::ACT_WAKE;
                            end else if (!latched_reg) begin
                                latched_next       = 1'b1;
                                result_next.action = pbec_pkg::ACT_SHUTDOWN;
                            end
                        end
                    end
                end
                pbec_pkg::OP_OPEN: begin
                    if (any_free) begin
                        in_use_next[free_slot]  = 1'b1;
                        result_next.new_session = 8'(free_slot);
                    end else begin
                        result_next.status = pbec_pkg::ST_NODEV;
                    end
                end
                pbec_pkg::OP_CLOSE: begin
                    if (owner_reg == pop_word.session) begin
                        owner_next = 8'd0;
                    end
                    in_use_next[SLOT_BITS'(pop_word.session)] = 1'b0;
                end
                pbec_pkg::OP_CLAIM: begin
                    if (owner_reg != 8'd0) begin
                        result_next.status = pbec_pkg::ST_BUSY;
                    end else begin
                        owner_next = pop_word.session;
                    end
                end
                pbec_pkg::OP_RELEASE: begin
                    if (owner_reg == 8'd0) begin
                        result_next.status = pbec_pkg::ST_NODEV;
                    end else if (owner_reg != pop_word.session) begin
                        result_next.status = pbec_pkg::ST_INVALID;
                    end else begin
                        owner_next = 8'd0;
                    end
                end
                pbec_pkg::OP_READ: begin
                    result_next.event_pending = pending_reg;
                    pending_next              = 1'b0;
                end
                pbec_pkg::OP_CREATE: begin
                    pending_next = 1'b1;
                    if (owner_reg != 8'd0) begin
                        result_next.action = pbec_pkg::ACT_WAKE;
                    end else if (!latched_reg) begin
                        latched_next       = 1'b1;
                        result_next.action = pbec_pkg::ACT_SHUTDOWN;
                    end
                end
                pbec_pkg::OP_POLL: result_next.event_pending = pending_reg;
                default:           result_next.status = pbec_pkg::ST_INVALID;
            endcase
        end
    end

    // Group full flags follow the slot table; slot 0 counts as taken.
    always_comb begin
        for (int g = 0; g < pbec_pkg::GROUP_COUNT; g++) begin
            group_full_next[g] = &(in_use_next[g * pbec_pkg::GROUP_SIZE +: pbec_pkg::GROUP_SIZE]
                                   | ((g == 0) ? pbec_pkg::GROUP_SIZE'(1) : '0));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_counter_reg <= 4'd0;
            press_seen_reg    <= 1'b0;
            tslp_reg          <= 17'd0;
            armed_reg         <= 1'b0;
            tsfp_reg          <= 17'd0;
            pending_reg       <= 1'b0;
            owner_reg         <= 8'd0;
            latched_reg       <= 1'b0;
            in_use_reg        <= '0;
            group_full_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            press_counter_reg <= press_counter_next;
            press_seen_reg    <= press_seen_next;
            tslp_reg          <= tslp_next;
            armed_reg         <= armed_next;
            tsfp_reg          <= tsfp_next;
            pending_reg       <= pending_next;
            owner_reg         <= owner_next;
            latched_reg       <= latched_next;
            in_use_reg        <= in_use_next;
            group_full_reg    <= group_full_next;
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word register.
    always_ff @(posedge aclk) begin
        if (pop) begin
            result_reg <= result_next;
        end
    end

endmodule

@@ sv/power_button_event_controller.sv @@
// Power button event controller. Each input word is one command (notify,
// tick, session open or close, monitor claim or release, event read,
// event create, poll) and yields exactly one result word. One word is
// taken per clock cycle while the receiver keeps up. The decoded command
// word is written into the two-entry queue when it is accepted and is
// executed from there into the result register once that register is
// empty or being taken. With the receiver stalled, the queue and the
// result register hold three words before the input stops accepting.
// The open command finds the lowest free session slot above 0 in the
// cycle that executes it, through a search over sixteen group-full
// flags and then sixteen slots of the chosen group.
// Configuration words are taken at any time and must only be written
// while no command is in flight.
module power_button_event_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_command,
    input  logic [7:0]  s_notify_code,
    input  logic [7:0]  s_session,
    input  logic        s_privileged,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [1:0]  m_action,
    output logic        m_event_pending,
    output logic [7:0]  m_new_session,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    pbec_pkg::cfg_t    cfg_reg;
    pbec_pkg::work_t   push_word;
    pbec_pkg::work_t   pop_word;
    pbec_pkg::result_t result;
    logic              push;
    logic              queue_ready;
    logic              pop;
    logic              pop_valid;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.button_enable      <= 1'b1;
            cfg_reg.abort_enable       <= 1'b1;
            cfg_reg.debugger_present   <= 1'b0;
            cfg_reg.abort_press_count  <= 4'd3;
            cfg_reg.abort_window_ticks <= 16'd1500;
        end else if (cfg_valid) begin
            case (cfg_index)
                pbec_pkg::CFG_BUTTON_ENABLE: cfg_reg.button_enable      <= cfg_data[0];
                pbec_pkg::CFG_ABORT_ENABLE:  cfg_reg.abort_enable       <= cfg_data[0];
                pbec_pkg::CFG_DEBUGGER:      cfg_reg.debugger_present   <= cfg_data[0];
                pbec_pkg::CFG_PRESS_COUNT:   cfg_reg.abort_press_count  <= cfg_data[3:0];
                pbec_pkg::CFG_WINDOW_TICKS:  cfg_reg.abort_window_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    pbec_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_notify_code (s_notify_code),
        .s_session     (s_session),
        .s_privileged  (s_privileged),
        .cfg           (cfg_reg),
        .push          (push),
        .push_word     (push_word),
        .queue_ready   (queue_ready)
    );

    pbec_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_word  (push_word),
        .push_ready (queue_ready),
        .pop        (pop),
        .pop_word   (pop_word),
        .pop_valid  (pop_valid)
    );

    pbec_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_word  (pop_word),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .result    (result)
    );

    assign m_status        = result.status;
    assign m_action        = result.action;
    assign m_event_pending = result.event_pending;
    assign m_new_session   = result.new_session;

    // No result word may be left over from before a reset.
    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    // A session number is only handed out by a successful open.
    a_session_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_new_session != 8'd0) |->
            (m_status == pbec_pkg::ST_OK && m_action == pbec_pkg::ACT_NONE
             && !m_event_pending))
        else $error("session number with a failed or foreign command");

    // Any action comes from a command that succeeded.
    a_action_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_action != pbec_pkg::ACT_NONE) |-> (m_status == pbec_pkg::ST_OK))
        else $error("action raised together with an error status");

endmodule
